>>> hw/rtl/status_led_effect_generator_top_defines.svh
// Assertion macros for the status LED effect generator checker.
`ifndef STATUS_LED_EFFECT_GENERATOR_TOP_DEFINES_SVH
`define STATUS_LED_EFFECT_GENERATOR_TOP_DEFINES_SVH

// Clocked assertion, switched off while reset is high.
`define SLG_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define SLG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/slg_pkg.sv
// Types and constants shared by the status LED effect generator.
`default_nettype none
package slg_pkg;

   localparam int STEP_WIDTH      = 6;
   localparam int DUTY_WIDTH      = 8;
   localparam int LEVEL_WIDTH     = 17;
   localparam int ANGLE_WIDTH     = 15;
   localparam int MODE_WIDTH      = 3;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 8;

   typedef enum logic [MODE_WIDTH-1:0] {
      LED_NORMAL = 3'd0,
      LED_BOOT   = 3'd1,
      LED_RESET  = 3'd2,
      LED_ERROR  = 3'd3,
      LED_WARN   = 3'd4,
      LED_OFF    = 3'd5
   } led_mode_type;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LED_MODE        = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_USER_BRIGHTNESS = 2'd1;

   localparam logic [DUTY_WIDTH-1:0] BRIGHTNESS_RESET = 8'd128;
   localparam logic [DUTY_WIDTH-1:0] DUTY_FULL        = 8'd255;

   typedef enum logic [1:0] {
      WAVE_LEVEL   = 2'd0,
      WAVE_BREATHE = 2'd1,
      WAVE_BLINK   = 2'd2
   } wave_kind_type;

   // Controls the step counter sees from the handshake and CSR side.
   typedef struct packed {
      logic accept;
      logic advance;
      logic mode_write;
   } step_ctl_type;

   // Quarter-wave cosine, Q1.16, pi/64 per entry.
   localparam int COS_ENTRIES = 33;
   localparam logic [LEVEL_WIDTH-1:0] COS_Q16 [COS_ENTRIES] = '{
      17'd65536, 17'd65457, 17'd65220, 17'd64827, 17'd64277, 17'd63572, 17'd62714, 17'd61705,
      17'd60547, 17'd59244, 17'd57798, 17'd56212, 17'd54491, 17'd52639, 17'd50660, 17'd48559,
      17'd46341, 17'd44011, 17'd41576, 17'd39040, 17'd36410, 17'd33692, 17'd30893, 17'd28020,
      17'd25080, 17'd22078, 17'd19024, 17'd15924, 17'd12785, 17'd9616,  17'd6424,  17'd3216,
      17'd0
   };

endpackage
`default_nettype wire

>>> hw/rtl/slg_step_counter.sv
// Elapsed-step counter: wraps at the mode's period, cleared by a mode write.
`default_nettype none
module slg_step_counter
   import slg_pkg::*;
#(
   parameter int SLOW_PERIOD_STEPS = 50,
   parameter int FAST_PERIOD_STEPS = 15
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [MODE_WIDTH-1:0] led_mode,
   input  wire step_ctl_type          ctl,
   output logic      [STEP_WIDTH-1:0] step_cur,
   output logic                       periodic,
   output logic                       slow
);

   localparam logic [STEP_WIDTH-1:0] SlowPeriod = STEP_WIDTH'(SLOW_PERIOD_STEPS);
   localparam logic [STEP_WIDTH-1:0] FastPeriod = STEP_WIDTH'(FAST_PERIOD_STEPS);

   logic [STEP_WIDTH-1:0] elapsed_ff;
   logic [STEP_WIDTH-1:0] elapsed_in;
   logic [STEP_WIDTH-1:0] period;
   logic [STEP_WIDTH:0]   step_inc;
   logic [STEP_WIDTH-1:0] step_adv;

   assign periodic = (led_mode == LED_BOOT) || (led_mode == LED_RESET) ||
                     (led_mode == LED_ERROR) || (led_mode == LED_WARN);
   assign slow     = (led_mode == LED_BOOT) || (led_mode == LED_WARN);
   assign period   = slow ? SlowPeriod : FastPeriod;

   // out-of-range count reads as zero
   assign step_cur = (periodic && (elapsed_ff < period)) ? elapsed_ff : '0;
   assign step_inc = {1'b0, step_cur} + 1'b1;
   assign step_adv = (step_inc >= {1'b0, period}) ? '0 : step_inc[STEP_WIDTH-1:0];

   always_comb begin
      elapsed_in = elapsed_ff;
      if (ctl.mode_write) begin
         elapsed_in = '0;
      end else if (ctl.accept) begin
         if (!periodic) begin
            elapsed_in = '0;
         end else if (ctl.advance) begin
            elapsed_in = step_adv;
         end else begin
            elapsed_in = step_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff <= '0;
      end else begin
         elapsed_ff <= elapsed_in;
      end
   end

endmodule
`default_nettype wire

>>> hw/rtl/slg_wave.sv
// Waveform shaping: raised-cosine level and blink phase for one step.
`default_nettype none
module slg_wave
   import slg_pkg::*;
#(
   parameter int SLOW_PERIOD_STEPS = 50,
   parameter int FAST_PERIOD_STEPS = 15
) (
   input  wire logic [STEP_WIDTH-1:0]  step,
   input  wire logic                   slow,
   output logic      [LEVEL_WIDTH-1:0] level,
   output logic                        blink_on
);

   localparam int StepCount = 2 ** STEP_WIDTH;
   localparam logic [STEP_WIDTH:0] SlowPeriod = (STEP_WIDTH+1)'(SLOW_PERIOD_STEPS);
   localparam logic [STEP_WIDTH:0] FastPeriod = (STEP_WIDTH+1)'(FAST_PERIOD_STEPS);

   logic [ANGLE_WIDTH-1:0] slow_angle [StepCount];
   logic [ANGLE_WIDTH-1:0] fast_angle [StepCount];

   // angle = step * 32768 / period, in pi/16384 units, fixed at elaboration
   for (genvar g = 0; g < StepCount; g++) begin : g_angle
      localparam int SlowA = (g * 32768) / SLOW_PERIOD_STEPS;
      localparam int FastA = (g * 32768) / FAST_PERIOD_STEPS;
      assign slow_angle[g] = SlowA[ANGLE_WIDTH-1:0];
      assign fast_angle[g] = FastA[ANGLE_WIDTH-1:0];
   end

   logic [ANGLE_WIDTH-1:0] angle;
   logic [ANGLE_WIDTH:0]   folded;
   logic                   upper;
   logic [13:0]            x;
   logic [5:0]             idx;
   logic [5:0]             idx_next;
   logic [7:0]             frac;
   logic [LEVEL_WIDTH-1:0] t0;
   logic [LEVEL_WIDTH-1:0] t1;
   logic [LEVEL_WIDTH-1:0] diff;
   logic [LEVEL_WIDTH+7:0] prod;
   logic [LEVEL_WIDTH-1:0] v;
   logic [LEVEL_WIDTH:0]   sum;

   assign angle  = slow ? slow_angle[step] : fast_angle[step];
   assign folded = (angle >= 15'd16384) ? (16'd32768 - {1'b0, angle}) : {1'b0, angle};
   assign upper  = folded > 16'd8192;
   assign x      = upper ? 14'(16'd16384 - folded) : folded[13:0];

   assign idx      = x[13:8];
   assign frac     = x[7:0];
   assign idx_next = (idx == 6'd32) ? idx : idx + 6'd1;
   assign t0       = COS_Q16[idx];
   assign t1       = COS_Q16[idx_next];
   assign diff     = t0 - t1;
   assign prod     = diff * frac;
   assign v        = t0 - prod[LEVEL_WIDTH+7:8];

   assign sum   = upper ? ({1'b0, 17'd65536} + {1'b0, v}) : ({1'b0, 17'd65536} - {1'b0, v});
   assign level = sum[LEVEL_WIDTH:1];

   assign blink_on = ({step, 1'b0} < (slow ? SlowPeriod : FastPeriod));

endmodule
`default_nettype wire

>>> hw/rtl/status_led_effect_generator_top.sv
// Status LED effect generator: mode registers, step counter and duty pipeline.
//
//   channel  dir  ports                                          beat
//   req      in   req_valid req_stall req_advance                one tick
//   rsp      out  rsp_valid rsp_stall rsp_duty rsp_step_index    one duty per tick
//   csr      in   csr_write_enable csr_index csr_write_data      register write
//
// Three register stages: tick capture, waveform level, scaled duty.
// A beat passes these registers in order from accept to rsp_valid; one beat per cycle while rsp is not stalled.
// The step counter advances at accept, so back-to-back ticks never wait on
// the pipeline; only a full pipeline behind a stalled rsp stalls req.
// reset (synchronous) empties the pipeline, sets mode normal, brightness 128.
`default_nettype none
module status_led_effect_generator_top
   import slg_pkg::*;
#(
   parameter int SLOW_PERIOD_STEPS = 50,
   parameter int FAST_PERIOD_STEPS = 15
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic                       req_advance,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic      [DUTY_WIDTH-1:0]      rsp_duty,
   output logic      [STEP_WIDTH-1:0]      rsp_step_index,
   input  wire logic                       csr_write_enable,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   // ---- configuration registers ----
   logic [MODE_WIDTH-1:0] led_mode_ff;
   logic [DUTY_WIDTH-1:0] user_brightness_ff;
   logic                  mode_write;

   assign mode_write = csr_write_enable && (csr_index == CSR_LED_MODE);

   always_ff @(posedge clock) begin
      if (reset) begin
         led_mode_ff        <= LED_NORMAL;
         user_brightness_ff <= BRIGHTNESS_RESET;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_LED_MODE) begin
            led_mode_ff <= csr_write_data[MODE_WIDTH-1:0];
         end
         if (csr_index == CSR_USER_BRIGHTNESS) begin
            user_brightness_ff <= csr_write_data[DUTY_WIDTH-1:0];
         end
      end
   end

   // ---- flow control: each stage moves when the one ahead is free ----
   logic s1_valid_ff;
   logic s2_valid_ff;
   logic rsp_valid_ff;
   logic out_ready;
   logic s2_ready;
   logic s1_ready;
   logic req_accept;

   assign out_ready  = !rsp_valid_ff || !rsp_stall;
   assign s2_ready   = !s2_valid_ff || out_ready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_stall  = !s1_ready;
   assign req_accept = req_valid && s1_ready;

   // ---- step counter ----
   step_ctl_type          step_ctl;
   logic [STEP_WIDTH-1:0] step_cur;
   logic                  periodic;
   logic                  slow;

   assign step_ctl.accept     = req_accept;
   assign step_ctl.advance    = req_advance;
   assign step_ctl.mode_write = mode_write;

   slg_step_counter #(
      .SLOW_PERIOD_STEPS(SLOW_PERIOD_STEPS),
      .FAST_PERIOD_STEPS(FAST_PERIOD_STEPS)
   ) u_step_counter (
      .clock    (clock),
      .reset    (reset),
      .led_mode (led_mode_ff),
      .ctl      (step_ctl),
      .step_cur (step_cur),
      .periodic (periodic),
      .slow     (slow)
   );

   // Mode decode at accept: waveform kind and peak (constant duty for level kind).
   wave_kind_type         kind_in;
   logic [DUTY_WIDTH-1:0] peak_in;

   always_comb begin
      kind_in = WAVE_LEVEL;
      peak_in = '0;
      unique case (led_mode_ff)
         LED_NORMAL: peak_in = user_brightness_ff;
         LED_BOOT,
         LED_RESET: begin
            kind_in = WAVE_BREATHE;
            peak_in = DUTY_FULL;
         end
         LED_ERROR: begin
            kind_in = WAVE_BLINK;
            peak_in = DUTY_FULL;
         end
         LED_WARN: begin
            kind_in = WAVE_BLINK;
            peak_in = user_brightness_ff;
         end
         default: peak_in = '0; // off and unused codes
      endcase
   end

   // ---- stage 1: captured tick ----
   logic [STEP_WIDTH-1:0] s1_step_ff;
   logic                  s1_slow_ff;
   wave_kind_type         s1_kind_ff;
   logic [DUTY_WIDTH-1:0] s1_peak_ff;

   // ---- stage 2: waveform level ----
   logic [STEP_WIDTH-1:0]  s2_step_ff;
   wave_kind_type          s2_kind_ff;
   logic [DUTY_WIDTH-1:0]  s2_peak_ff;
   logic [LEVEL_WIDTH-1:0] s2_level_ff;
   logic                   s2_blink_on_ff;

   logic [LEVEL_WIDTH-1:0] wave_level;
   logic                   wave_blink_on;

   slg_wave #(
      .SLOW_PERIOD_STEPS(SLOW_PERIOD_STEPS),
      .FAST_PERIOD_STEPS(FAST_PERIOD_STEPS)
   ) u_wave (
      .step     (s1_step_ff),
      .slow     (s1_slow_ff),
      .level    (wave_level),
      .blink_on (wave_blink_on)
   );

   // ---- stage 3: duty = level * peak >> 16 (breathe), peak or zero (blink), peak (level) ----
   logic [DUTY_WIDTH-1:0]             rsp_duty_ff;
   logic [STEP_WIDTH-1:0]             rsp_step_index_ff;
   logic [LEVEL_WIDTH+DUTY_WIDTH-1:0] scaled;
   logic [DUTY_WIDTH-1:0]             duty_in;

   assign scaled = s2_level_ff * s2_peak_ff;

   always_comb begin
      unique case (s2_kind_ff)
         WAVE_BREATHE: duty_in = scaled[16 +: DUTY_WIDTH];
         WAVE_BLINK:   duty_in = s2_blink_on_ff ? s2_peak_ff : '0;
         default:      duty_in = s2_peak_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (out_ready) begin
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_step_ff <= step_cur;
         s1_slow_ff <= periodic && slow;
         s1_kind_ff <= kind_in;
         s1_peak_ff <= peak_in;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_step_ff     <= s1_step_ff;
         s2_kind_ff     <= s1_kind_ff;
         s2_peak_ff     <= s1_peak_ff;
         s2_level_ff    <= wave_level;
         s2_blink_on_ff <= wave_blink_on;
      end
      if (out_ready && s2_valid_ff) begin
         rsp_duty_ff       <= duty_in;
         rsp_step_index_ff <= s2_step_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_duty       = rsp_duty_ff;
   assign rsp_step_index = rsp_step_index_ff;

endmodule
`default_nettype wire

>>> hw/rtl/slg_checker.sv
// Port-level checker for the status LED effect generator, bound to the top.
`default_nettype none
`include "status_led_effect_generator_top_defines.svh"
module slg_checker
   import slg_pkg::*;
#(
   parameter int SLOW_PERIOD_STEPS = 50,
   parameter int FAST_PERIOD_STEPS = 15
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_stall,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire logic [DUTY_WIDTH-1:0] rsp_duty,
   input wire logic [STEP_WIDTH-1:0] rsp_step_index
);

   localparam int MaxPeriod = (SLOW_PERIOD_STEPS > FAST_PERIOD_STEPS) ?
                              SLOW_PERIOD_STEPS : FAST_PERIOD_STEPS;
   localparam logic [STEP_WIDTH:0] MaxPeriodW = (STEP_WIDTH+1)'(MaxPeriod);

   `SLG_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_duty) && $stable(rsp_step_index), "rsp beat changed while stalled")

   `SLG_ASSERT(a_step_range, clock, reset, rsp_valid |-> ({1'b0, rsp_step_index} < MaxPeriodW), "step index beyond longest period")

   `SLG_ASSERT(a_stall_only_when_full, clock, reset, req_stall |-> rsp_valid && rsp_stall, "req stalled while rsp side can drain")

   `SLG_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !rsp_valid, "rsp valid right after reset")

endmodule

bind status_led_effect_generator_top slg_checker #(
   .SLOW_PERIOD_STEPS(SLOW_PERIOD_STEPS),
   .FAST_PERIOD_STEPS(FAST_PERIOD_STEPS)
) u_slg_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_duty       (rsp_duty),
   .rsp_step_index (rsp_step_index)
);
`default_nettype wire
